[design/bhi_pkg.sv]
// ----------------------------------------------------------------------------
// bhi_pkg - shared types and microcode for the heap insert block
// Item and result beats, status codes and the control store of the
// step sequencer that runs inserts and reads.
// ----------------------------------------------------------------------------
package bhi_pkg;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] data_value;
        logic        [7:0]  read_index;
    } t_item;

    typedef struct packed {
        logic signed [31:0] entry_value;
        logic signed [31:0] root_value;
        logic        [8:0]  entry_count;
        t_status            status;
    } t_result;

    // control store addresses
    typedef enum logic [3:0] {
        S_WAIT     = 4'd0,
        S_DISPATCH = 4'd1,
        S_CHKFULL  = 4'd2,
        S_LOOP     = 4'd3,
        S_CMP      = 4'd4,
        S_MOVE     = 4'd5,
        S_PLACE    = 4'd6,
        S_EMIT     = 4'd7,
        S_FULL     = 4'd8,
        S_RD       = 4'd9,
        S_RDWAIT   = 4'd10,
        S_BADIDX   = 4'd11
    } t_step;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_IS_READ,
        C_FULL,
        C_POS_ZERO,
        C_NOT_ABOVE,
        C_OUT_BUSY,
        C_BAD_IDX
    } t_cond;

    // memory read address select
    typedef enum logic [1:0] {
        RS_NONE,
        RS_PARENT,
        RS_INDEX
    } t_rsel;

    // datapath operation
    typedef enum logic [2:0] {
        DP_NONE,
        DP_MOVE,
        DP_PLACE,
        DP_FULL,
        DP_GRAB,
        DP_BAD,
        DP_EMIT
    } t_dop;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  fin;
        logic  take;
        t_rsel rsel;
        t_dop  dop;
    } t_uword;

    typedef struct packed {
        logic beat;
        logic is_read;
        logic full;
        logic pos_zero;
        logic not_above;
        logic out_busy;
        logic bad_idx;
    } t_flags;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{cond: C_NEVER, target: S_WAIT, fin: 1'b0, take: 1'b0,
              rsel: RS_NONE, dop: DP_NONE};
        case (step)
            S_WAIT: begin
                w.cond   = C_NO_BEAT;
                w.target = S_WAIT;
                w.take   = 1'b1;
            end
            S_DISPATCH: begin
                w.cond   = C_IS_READ;
                w.target = S_RD;
            end
            S_CHKFULL: begin
                w.cond   = C_FULL;
                w.target = S_FULL;
            end
            S_LOOP: begin
                w.cond   = C_POS_ZERO;
                w.target = S_PLACE;
                w.rsel   = RS_PARENT;
            end
            S_CMP: begin
                w.cond   = C_NOT_ABOVE;
                w.target = S_PLACE;
            end
            S_MOVE: begin
                w.cond   = C_ALWAYS;
                w.target = S_LOOP;
                w.dop    = DP_MOVE;
            end
            S_PLACE: begin
                w.dop    = DP_PLACE;
            end
            S_EMIT: begin
                w.cond   = C_OUT_BUSY;
                w.target = S_EMIT;
                w.fin    = 1'b1;
                w.dop    = DP_EMIT;
            end
            S_FULL: begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT;
                w.dop    = DP_FULL;
            end
            S_RD: begin
                w.cond   = C_BAD_IDX;
                w.target = S_BADIDX;
                w.rsel   = RS_INDEX;
            end
            S_RDWAIT: begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT;
                w.dop    = DP_GRAB;
            end
            S_BADIDX: begin
                w.cond   = C_ALWAYS;
                w.target = S_EMIT;
                w.dop    = DP_BAD;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

[design/bhi_ram.sv]
// ----------------------------------------------------------------------------
// bhi_ram - generic single write, single read ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bhi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bhi_useq.sv]
// ----------------------------------------------------------------------------
// bhi_useq - step sequencer
// Step counter over the control store with conditional jumps.
// ----------------------------------------------------------------------------
module bhi_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bhi_pkg::t_flags i_flags,
    output bhi_pkg::t_uword o_uword
);

    bhi_pkg::t_step  r_step;
    bhi_pkg::t_step  n_step;
    bhi_pkg::t_uword w;
    logic            taken;

    // control word for the current step
    always_comb begin
        w = bhi_pkg::ucode(r_step);
    end

    assign o_uword = w;

    // jump condition and next step
    always_comb begin
        case (w.cond)
            bhi_pkg::C_NEVER:     taken = 1'b0;
            bhi_pkg::C_ALWAYS:    taken = 1'b1;
            bhi_pkg::C_NO_BEAT:   taken = ~i_flags.beat;
            bhi_pkg::C_IS_READ:   taken = i_flags.is_read;
            bhi_pkg::C_FULL:      taken = i_flags.full;
            bhi_pkg::C_POS_ZERO:  taken = i_flags.pos_zero;
            bhi_pkg::C_NOT_ABOVE: taken = i_flags.not_above;
            bhi_pkg::C_OUT_BUSY:  taken = i_flags.out_busy;
            bhi_pkg::C_BAD_IDX:   taken = i_flags.bad_idx;
            default:              taken = 1'b1;
        endcase
        if (taken) begin
            n_step = w.target;
        end else if (w.fin) begin
            n_step = bhi_pkg::S_WAIT;
        end else begin
            n_step = bhi_pkg::t_step'(4'(r_step) + 4'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bhi_pkg::S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

[design/binary_heap_insert.sv]
// ----------------------------------------------------------------------------
// binary_heap_insert - binary heap of signed 32-bit values
// Insert with sift-up and indexed read, max or min order, microcoded control.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data): one beat per item,
//   an insert of data_value or a read of the entry at read_index
//   output channel (o_out_valid / i_out_stall / o_out_data): one result beat
//   per item with the entry, the root, the count and a status code
//   config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): min_order bit,
//   always ready, to be written only while the block is idle
// timing
//   one item at a time; o_in_stall is low only at the wait step
//   read: dispatch, indexed read, grab (or the bad-index step), emit
//   refused insert: dispatch, full check, full step, emit
//   insert: dispatch, full check, then for each level climbed a parent
//   read, a compare on the registered read data and a write of the parent
//   into the hole, then the place step and emit
// reset
//   synchronous, clears the count, order bit, step counter and output valid;
//   heap memory is not cleared, entries beyond the count are never shown
// stall
//   a result waits in the output register; the sequencer holds at its
//   emit step while i_out_stall is high and that register is still occupied
// ----------------------------------------------------------------------------
module binary_heap_insert #(
    parameter int CAPACITY = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bhi_pkg::t_item    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bhi_pkg::t_result  o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    // sequencer control
    bhi_pkg::t_uword u;
    bhi_pkg::t_flags flags;
    logic            beat;

    // datapath registers
    bhi_pkg::t_item     r_item,   n_item;
    logic [AW-1:0]      r_pos,    n_pos;
    logic [CW-1:0]      r_count,  n_count;
    logic signed [31:0] r_root,   n_root;
    logic signed [31:0] r_entry,  n_entry;
    bhi_pkg::t_status   r_status, n_status;
    bhi_pkg::t_result   r_out,    n_out;
    logic               r_out_valid, n_out_valid;
    logic               r_min_order, n_min_order;

    // memory ports
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;
    logic signed [31:0] parent_value;

    logic [AW-1:0]      parent_pos;
    logic [XW-1:0]      idx_x;
    logic [XW-1:0]      count_x;
    logic [CW+8:0]      count_w;
    logic               load_out;
    logic signed [31:0] root_shown;

    bhi_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (u)
    );

    bhi_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // handshakes
    assign o_in_stall  = ~u.take;
    assign beat        = i_in_valid & u.take;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // address arithmetic
    assign parent_pos   = (r_pos - AW'(1)) >> 1;
    assign idx_x        = XW'(r_item.read_index);
    assign count_x      = XW'(r_count);
    assign count_w      = {9'd0, r_count};
    assign parent_value = $signed(mem_rdata);

    // condition flags for the sequencer
    always_comb begin
        flags.beat     = beat;
        flags.is_read  = (r_item.op == bhi_pkg::OP_READ);
        flags.full     = (r_count == CW'(CAPACITY));
        flags.pos_zero = (r_pos == '0);
        // hole stays put unless the new value strictly beats its parent
        if (r_min_order) begin
            flags.not_above = !(r_item.data_value < parent_value);
        end else begin
            flags.not_above = !(r_item.data_value > parent_value);
        end
        flags.out_busy = r_out_valid & i_out_stall;
        flags.bad_idx  = (idx_x >= count_x);
    end

    // memory port control: parent or indexed read, hole writes
    always_comb begin
        mem_re    = (u.rsel != bhi_pkg::RS_NONE);
        mem_raddr = (u.rsel == bhi_pkg::RS_PARENT) ? parent_pos : idx_x[AW-1:0];
        mem_we    = (u.dop == bhi_pkg::DP_MOVE) || (u.dop == bhi_pkg::DP_PLACE);
        mem_waddr = r_pos;
        mem_wdata = (u.dop == bhi_pkg::DP_MOVE) ? mem_rdata : r_item.data_value;
    end

    // datapath next values
    always_comb begin
        n_item      = beat ? i_in_data : r_item;
        n_pos       = r_pos;
        n_count     = r_count;
        n_root      = r_root;
        n_entry     = r_entry;
        n_status    = r_status;
        n_min_order = i_cfg_valid ? i_cfg_data : r_min_order;

        if (beat) begin
            // hole starts at the first free slot
            n_pos    = r_count[AW-1:0];
            n_entry  = i_in_data.data_value;
            n_status = bhi_pkg::ST_OK;
        end

        case (u.dop)
            bhi_pkg::DP_MOVE: begin
                // parent drops into the hole, hole climbs one level
                n_pos = parent_pos;
            end
            bhi_pkg::DP_PLACE: begin
                n_count = r_count + CW'(1);
                if (r_pos == '0) begin
                    n_root = r_item.data_value;
                end
            end
            bhi_pkg::DP_FULL: begin
                n_status = bhi_pkg::ST_FULL;
            end
            bhi_pkg::DP_GRAB: begin
                n_entry = parent_value;
            end
            bhi_pkg::DP_BAD: begin
                n_entry  = '0;
                n_status = bhi_pkg::ST_RANGE;
            end
            default: begin
            end
        endcase
    end

    // output register
    assign root_shown = (r_count != '0) ? r_root : 32'sd0;
    assign load_out   = (u.dop == bhi_pkg::DP_EMIT) & ~flags.out_busy;

    always_comb begin
        n_out = r_out;
        if (load_out) begin
            n_out.entry_value = r_entry;
            n_out.root_value  = root_shown;
            n_out.entry_count = count_w[8:0];
            n_out.status      = r_status;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_min_order <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_min_order <= n_min_order;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_pos    <= n_pos;
        r_root   <= n_root;
        r_entry  <= n_entry;
        r_status <= n_status;
        r_out    <= n_out;
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("heap count beyond capacity");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("heap memory read and written in one step");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == bhi_pkg::ST_FULL) |-> flags.full)
        else $error("full status while heap has room");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == bhi_pkg::ST_RANGE) |-> (r_out.entry_value == 32'sd0))
        else $error("out of range read gave nonzero entry");

    a_take_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat |=> o_in_stall)
        else $error("second item taken before the first finished");

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the binary heap insert block
// Feeds insert and read beats through the valid/stall input channel, keeps a
// shadow heap that sifts each insert up under the current order, and checks
// every result beat field by field. Runs four idling phases with the order
// bit rewritten between them, plus one long output hold that backs the
// block up.
// ----------------------------------------------------------------------------
module tb;

    localparam int HEAP_DEPTH      = 256;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_AFTER      = 40;    // input beats before the long hold
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 3000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    bhi_pkg::t_item   in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    bhi_pkg::t_result out_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_data  = 1'b0;

    binary_heap_insert #(
        .CAPACITY(HEAP_DEPTH)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow heap, updated when an input beat is accepted
    logic signed [31:0] heap_vals [HEAP_DEPTH];
    int                 heap_size   = 0;
    logic               min_at_root = 1'b0;

    bhi_pkg::t_item   item_backlog [$];   // items waiting for the driver
    bhi_pkg::t_result due_results  [$];   // predicted result beats, oldest first

    int  n_queued     = 0;
    int  n_accepted   = 0;
    int  fail_count   = 0;
    int  quiet_cycles = 0;
    int  gen_count    = 0;       // heap size as the generator sees it
    int  snd_idle_pct = 0;
    int  rcv_stall_pct = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  in_acc       = 1'b0;    // input beat taken at the last rising edge
    bit  out_acc      = 1'b0;
    bit  cfg_acc      = 1'b0;

    // true when a must sit above b under the current order
    function automatic bit outranks(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
        return min_at_root ? (a < b) : (a > b);
    endfunction

    // apply one item to the shadow heap and return the result it gives
    function automatic bhi_pkg::t_result heap_step(input bhi_pkg::t_item item);
        bhi_pkg::t_result   r;
        int                 pos;
        int                 parent;
        logic signed [31:0] tmp;
        bit                 climbing;
        r.entry_value = '0;
        r.status      = bhi_pkg::ST_OK;
        if (item.op == bhi_pkg::OP_INSERT) begin
            r.entry_value = item.data_value;
            if (heap_size >= HEAP_DEPTH) begin
                // full heap: nothing moves, only the flag
                r.status = bhi_pkg::ST_FULL;
            end else begin
                pos            = heap_size;
                heap_vals[pos] = item.data_value;
                climbing       = 1'b1;
                // sift up, equal values stay below their parent
                while (climbing && pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (outranks(heap_vals[pos], heap_vals[parent])) begin
                        tmp               = heap_vals[pos];
                        heap_vals[pos]    = heap_vals[parent];
                        heap_vals[parent] = tmp;
                        pos               = parent;
                    end else begin
                        climbing = 1'b0;
                    end
                end
                heap_size++;
            end
        end else begin
            if (int'(item.read_index) < heap_size) begin
                r.entry_value = heap_vals[item.read_index];
            end else begin
                r.status = bhi_pkg::ST_RANGE;
            end
        end
        r.root_value  = (heap_size > 0) ? heap_vals[0] : 32'sd0;
        r.entry_count = 9'(heap_size);
        return r;
    endfunction

    // values biased toward ties and the ends of the range
    function automatic logic signed [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(3))
            0: v = 32'(int'($urandom_range(16)) - 8);
            1: begin
                case ($urandom_range(3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic queue_item(input bhi_pkg::t_op op, input logic signed [31:0] value,
                              input logic [7:0] index);
        bhi_pkg::t_item item;
        item.op         = op;
        item.data_value = value;
        item.read_index = index;
        if (op == bhi_pkg::OP_INSERT && gen_count < HEAP_DEPTH)
            gen_count++;
        item_backlog.push_back(item);
        n_queued++;
    endtask

    // inserts about 40 percent of the time, reads mostly inside the heap
    task automatic queue_random();
        logic [7:0] index;
        if ($urandom_range(99) < 40) begin
            queue_item(bhi_pkg::OP_INSERT, pick_value(), 8'($urandom));
        end else begin
            if (gen_count > 0 && $urandom_range(99) < 80)
                index = 8'($urandom_range(gen_count - 1));
            else
                index = 8'($urandom);
            queue_item(bhi_pkg::OP_READ, $urandom, index);
        end
    endtask

    // block idle: every item taken and every result back
    task automatic settle();
        while (n_accepted != n_queued || due_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_order(input logic min_first);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= min_first;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // input driver: a new beat only once the previous one was taken
    always @(negedge clk) begin
        if (rst_n && (!in_valid || in_acc)) begin
            if (item_backlog.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= item_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall driver, with one long hold while the sender keeps going
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rcv_stall_pct);
        end
    end

    // monitor: predict on input beats, check on result beats
    always @(posedge clk) begin
        bhi_pkg::t_result exp_res;
        in_acc  = rst_n && in_valid && !in_stall;
        out_acc = rst_n && out_valid && !out_stall;
        cfg_acc = rst_n && cfg_valid && cfg_ready;
        if (cfg_acc)
            min_at_root = cfg_data;
        // check first so a beat taken at this edge cannot mask a stray result
        if (out_acc) begin
            if (due_results.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                exp_res = due_results.pop_front();
                if (out_data.entry_value !== exp_res.entry_value) begin
                    $error("entry_value: expected %0d, got %0d",
                           exp_res.entry_value, out_data.entry_value);
                    fail_count++;
                end
                if (out_data.root_value !== exp_res.root_value) begin
                    $error("root_value: expected %0d, got %0d",
                           exp_res.root_value, out_data.root_value);
                    fail_count++;
                end
                if (out_data.entry_count !== exp_res.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_res.entry_count, out_data.entry_count);
                    fail_count++;
                end
                if (out_data.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d",
                           exp_res.status, out_data.status);
                    fail_count++;
                end
            end
        end
        if (in_acc) begin
            due_results.push_back(heap_step(in_data));
            n_accepted++;
        end
        // watchdog on cycles with no beat on any channel
        if (rst_n) begin
            if (in_acc || out_acc || cfg_acc)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int k;
        int idx;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (phase = 0; phase < 4; phase++) begin
            settle();
            // no idling, sender idle, receiver stalling, then both
            case (phase)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 64; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 64; end
                default: begin snd_idle_pct = 34; rcv_stall_pct = 34; end
            endcase
            // order flips each phase, so later inserts land on a heap built
            // under the other order
            write_order(phase[0]);
            if (phase == 0) begin
                // empty heap reads, root shows zero
                queue_item(bhi_pkg::OP_READ, 32'sh5a5a5a5a, 8'd0);
                queue_item(bhi_pkg::OP_READ, -32'sd1, 8'd255);
                // extremes, a tie with the root, small values
                queue_item(bhi_pkg::OP_INSERT, 32'sd0, 8'hff);
                queue_item(bhi_pkg::OP_INSERT, 32'sh7fffffff, 8'h00);
                queue_item(bhi_pkg::OP_INSERT, 32'sh80000000, 8'hff);
                queue_item(bhi_pkg::OP_INSERT, -32'sd1, 8'h00);
                queue_item(bhi_pkg::OP_INSERT, 32'sh7fffffff, 8'h55);
                queue_item(bhi_pkg::OP_INSERT, 32'sd5, 8'haa);
                queue_item(bhi_pkg::OP_INSERT, 32'sd6, 8'h00);
                queue_item(bhi_pkg::OP_INSERT, 32'sh80000001, 8'h00);
                // every held entry, the first index past the count, the top
                for (idx = 0; idx <= 8; idx++)
                    queue_item(bhi_pkg::OP_READ, $urandom, 8'(idx));
                queue_item(bhi_pkg::OP_READ, 32'sh7fffffff, 8'd255);
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                queue_random();
        end
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
